[rtl/eikonal_grid_point_update_defines.svh]
// Assertion macros for the eikonal grid point update RTL.
`ifndef EIKONAL_GRID_POINT_UPDATE_DEFINES_SVH
`define EIKONAL_GRID_POINT_UPDATE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define EGPU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define EGPU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/egpu_pkg.sv]
// Types and constants of the eikonal grid point update block.
package egpu_pkg;

   localparam int VAL_W       = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_W       = VAL_W + FRAC_BITS;
   localparam int DIV_STAGES  = NUM_W;
   localparam int ROOT_W      = VAL_W + 1;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int REM_W       = ROOT_W + 3;
   localparam int DISC_W      = 2 * VAL_W + 1;
   localparam int CAND_W      = VAL_W + 2;
   localparam int NUM_NB      = 4;
   localparam int LATENCY     = 1 + DIV_STAGES + 3 + SQRT_STAGES + 3;

   localparam logic [VAL_W-1:0] GS_RESET = VAL_W'(1) << FRAC_BITS;
   localparam logic [VAL_W-1:0] VMAX     = '1;

   typedef struct packed {
      logic [VAL_W-1:0] north_value;
      logic [VAL_W-1:0] east_value;
      logic [VAL_W-1:0] south_value;
      logic [VAL_W-1:0] west_value;
      logic             north_valid;
      logic             east_valid;
      logic             south_valid;
      logic             west_valid;
      logic [VAL_W-1:0] speed;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] arrival_time;
      logic             unreachable;
   } rsp_type;

endpackage

[rtl/eikonal_grid_point_update.sv]
// Top level of the eikonal grid point update pipeline.
//
// Usage: a transaction carries four neighbour arrival times with their
// valid flags and the local speed in req_data; it is taken at a clock
// edge with start high (busy is always low, so every start is taken).
// The new arrival time and the unreachable flag appear on rsp_data for
// exactly one cycle with rsp_done high, once the transaction has passed
// the input, divider, difference, square, discriminant, square root,
// candidate and minimum registers; the receiver has no way to hold them off.
// Throughput is one transaction per cycle. Latency is set by the
// bit-per-stage divider for spacing/speed (48 stages) and the
// bit-per-stage square roots of the discriminants (33 stages), plus
// input, difference, square, discriminant, candidate and two minimum stages.
// The grid spacing register is written through csr_we/csr_wdata; the user must write it only
// while no transaction is in flight, as the block itself does not enforce it; it resets to 1.0 in Q16.16.
// Synchronous reset restores the grid spacing to 1.0 and drops all
// transactions in flight; no result is produced for them.
`include "eikonal_grid_point_update_defines.svh"

module eikonal_grid_point_update (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  egpu_pkg::req_type           req_data,
   output logic                        rsp_done,
   output egpu_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [egpu_pkg::VAL_W-1:0]  csr_wdata
);

   localparam int VW = egpu_pkg::VAL_W;
   localparam int NB = egpu_pkg::NUM_NB;

   logic [VW-1:0]              gs_ff;
   logic [egpu_pkg::LATENCY-1:0] vld_ff;
   egpu_pkg::req_type          req_ff;

   egpu_pkg::req_type          dreq_ff [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::NUM_W-1:0] quotient;

   logic [VW-1:0]              val_w [NB];
   logic                       ok_w  [NB];

   logic [VW-1:0]              a_rhs_ff;
   logic [VW-1:0]              a_val_ff  [NB];
   logic                       a_ok_ff   [NB];
   logic [VW-1:0]              a_diff_ff [NB];

   logic [2*VW-1:0]            b_r2_ff;
   logic [2*VW-1:0]            b_d2_ff   [NB];
   logic [VW-1:0]              b_rhs_ff;
   logic [VW-1:0]              b_val_ff  [NB];
   logic                       b_ok_ff   [NB];

   logic [egpu_pkg::DISC_W-1:0] c_disc_ff [NB];
   logic                        c_pos_ff  [NB];
   logic [VW-1:0]               c_rhs_ff;
   logic [VW-1:0]               c_val_ff  [NB];
   logic                        c_ok_ff   [NB];

   logic [VW-1:0]              s_rhs_ff [egpu_pkg::SQRT_STAGES];
   logic [VW-1:0]              s_val_ff [egpu_pkg::SQRT_STAGES][NB];
   logic                       s_ok_ff  [egpu_pkg::SQRT_STAGES][NB];
   logic                       s_pos_ff [egpu_pkg::SQRT_STAGES][NB];
   logic [egpu_pkg::ROOT_W-1:0] root_w  [NB];

   logic [egpu_pkg::CAND_W-1:0] e_cand_ff [NB];
   logic                        e_have_ff [NB];
   logic [egpu_pkg::CAND_W-1:0] e_cand_in [NB];
   logic                        e_have_in [NB];

   logic [egpu_pkg::CAND_W-1:0] f_cand_ff [2];
   logic                        f_have_ff [2];
   logic [egpu_pkg::CAND_W-1:0] f_cand_in [2];
   logic                        f_have_in [2];

   egpu_pkg::rsp_type           rsp_ff;
   egpu_pkg::rsp_type           rsp_in;

   logic                        accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Hold the grid spacing register
   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff <= egpu_pkg::GS_RESET;
      end else if (csr_we) begin
         gs_ff <= csr_wdata;
      end
   end

   // Advance the valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[egpu_pkg::LATENCY-2:0], accept};
      end
   end

   // Capture the input transaction
   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // Divide spacing by speed
   egpu_div u_div (
      .clock    (clock),
      .dividend ({gs_ff, egpu_pkg::FRAC_BITS'(0)}),
      .divisor  (req_ff.speed),
      .quotient (quotient)
   );

   // Delay the transaction to match the divider
   always_ff @(posedge clock) begin
      dreq_ff[0] <= req_ff;
      for (int s = 1; s < egpu_pkg::DIV_STAGES; s++) begin
         dreq_ff[s] <= dreq_ff[s-1];
      end
   end

   // Unpack neighbours in north, east, south, west order
   always_comb begin
      val_w[0] = dreq_ff[egpu_pkg::DIV_STAGES-1].north_value;
      val_w[1] = dreq_ff[egpu_pkg::DIV_STAGES-1].east_value;
      val_w[2] = dreq_ff[egpu_pkg::DIV_STAGES-1].south_value;
      val_w[3] = dreq_ff[egpu_pkg::DIV_STAGES-1].west_value;
      ok_w[0]  = dreq_ff[egpu_pkg::DIV_STAGES-1].north_valid;
      ok_w[1]  = dreq_ff[egpu_pkg::DIV_STAGES-1].east_valid;
      ok_w[2]  = dreq_ff[egpu_pkg::DIV_STAGES-1].south_valid;
      ok_w[3]  = dreq_ff[egpu_pkg::DIV_STAGES-1].west_valid;
   end

   // Stage A: saturate rhs, take pair differences
   always_ff @(posedge clock) begin
      a_rhs_ff <= (|quotient[egpu_pkg::NUM_W-1:VW]) ? egpu_pkg::VMAX : quotient[VW-1:0];
      for (int k = 0; k < NB; k++) begin
         a_val_ff[k]  <= val_w[k];
         a_ok_ff[k]   <= ok_w[k];
         a_diff_ff[k] <= (val_w[k] > val_w[(k+1)%NB]) ? val_w[k] - val_w[(k+1)%NB]
                                                       : val_w[(k+1)%NB] - val_w[k];
      end
   end

   // Stage B: square rhs and differences
   always_ff @(posedge clock) begin
      b_r2_ff  <= a_rhs_ff * a_rhs_ff;
      b_rhs_ff <= a_rhs_ff;
      for (int k = 0; k < NB; k++) begin
         b_d2_ff[k]  <= a_diff_ff[k] * a_diff_ff[k];
         b_val_ff[k] <= a_val_ff[k];
         b_ok_ff[k]  <= a_ok_ff[k];
      end
   end

   // Stage C: form discriminants
   always_ff @(posedge clock) begin
      c_rhs_ff <= b_rhs_ff;
      for (int k = 0; k < NB; k++) begin
         c_disc_ff[k] <= {b_r2_ff, 1'b0} - {1'b0, b_d2_ff[k]};
         c_pos_ff[k]  <= {b_r2_ff, 1'b0} > {1'b0, b_d2_ff[k]};
         c_val_ff[k]  <= b_val_ff[k];
         c_ok_ff[k]   <= b_ok_ff[k];
      end
   end

   // Square roots, one unit per neighbour pair
   for (genvar k = 0; k < NB; k++) begin : g_sqrt
      egpu_sqrt u_sqrt (
         .clock    (clock),
         .radicand ({1'b0, c_disc_ff[k]}),
         .root     (root_w[k])
      );
   end

   // Delay side data to match the square roots
   always_ff @(posedge clock) begin
      for (int s = 0; s < egpu_pkg::SQRT_STAGES; s++) begin
         s_rhs_ff[s] <= (s == 0) ? c_rhs_ff : s_rhs_ff[s == 0 ? 0 : s-1];
         for (int k = 0; k < NB; k++) begin
            s_val_ff[s][k] <= (s == 0) ? c_val_ff[k] : s_val_ff[s == 0 ? 0 : s-1][k];
            s_ok_ff[s][k]  <= (s == 0) ? c_ok_ff[k]  : s_ok_ff[s == 0 ? 0 : s-1][k];
            s_pos_ff[s][k] <= (s == 0) ? c_pos_ff[k] : s_pos_ff[s == 0 ? 0 : s-1][k];
         end
      end
   end

   // Stage E: build one candidate per pair
   always_comb begin
      logic [VW-1:0]                 t1;
      logic [VW-1:0]                 t2;
      logic                          o1;
      logic                          o2;
      logic [egpu_pkg::CAND_W:0]     sum;
      logic [egpu_pkg::CAND_W-1:0]   two;
      for (int k = 0; k < NB; k++) begin
         t1  = s_val_ff[egpu_pkg::SQRT_STAGES-1][k];
         t2  = s_val_ff[egpu_pkg::SQRT_STAGES-1][(k+1)%NB];
         o1  = s_ok_ff[egpu_pkg::SQRT_STAGES-1][k];
         o2  = s_ok_ff[egpu_pkg::SQRT_STAGES-1][(k+1)%NB];
         sum = (egpu_pkg::CAND_W+1)'(t1) + (egpu_pkg::CAND_W+1)'(t2)
             + (egpu_pkg::CAND_W+1)'(root_w[k]);
         two = sum[egpu_pkg::CAND_W:1];
         if (o1 && o2) begin
            e_cand_in[k] = two;
            e_have_in[k] = s_pos_ff[egpu_pkg::SQRT_STAGES-1][k]
                           && two >= egpu_pkg::CAND_W'(t1)
                           && two >= egpu_pkg::CAND_W'(t2);
         end else begin
            e_cand_in[k] = egpu_pkg::CAND_W'(o1 ? t1 : t2)
                         + egpu_pkg::CAND_W'(s_rhs_ff[egpu_pkg::SQRT_STAGES-1]);
            e_have_in[k] = o1 || o2;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NB; k++) begin
         e_cand_ff[k] <= e_cand_in[k];
         e_have_ff[k] <= e_have_in[k];
      end
   end

   // Stage F: pairwise minimum
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         f_have_in[j] = e_have_ff[2*j] || e_have_ff[2*j+1];
         if (e_have_ff[2*j] && (!e_have_ff[2*j+1] || e_cand_ff[2*j] <= e_cand_ff[2*j+1])) begin
            f_cand_in[j] = e_cand_ff[2*j];
         end else begin
            f_cand_in[j] = e_cand_ff[2*j+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         f_cand_ff[j] <= f_cand_in[j];
         f_have_ff[j] <= f_have_in[j];
      end
   end

   // Stage G: final minimum and saturation
   always_comb begin
      logic [egpu_pkg::CAND_W-1:0] best;
      if (f_have_ff[0] && (!f_have_ff[1] || f_cand_ff[0] <= f_cand_ff[1])) begin
         best = f_cand_ff[0];
      end else begin
         best = f_cand_ff[1];
      end
      if (!f_have_ff[0] && !f_have_ff[1]) begin
         rsp_in.arrival_time = egpu_pkg::VMAX;
         rsp_in.unreachable  = 1'b1;
      end else begin
         rsp_in.arrival_time = (|best[egpu_pkg::CAND_W-1:VW]) ? egpu_pkg::VMAX
                                                               : best[VW-1:0];
         rsp_in.unreachable  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_done = vld_ff[egpu_pkg::LATENCY-1];
   assign rsp_data = rsp_ff;

   `EGPU_ASSERT_ALWAYS(a_never_busy, clock, !busy, "busy raised")
   `EGPU_ASSERT(a_done_latency, clock, reset, rsp_done |-> $past(start, egpu_pkg::LATENCY), "result without matching transaction")
   `EGPU_ASSERT(a_unreach_sat, clock, reset, (rsp_done && rsp_data.unreachable) |-> (rsp_data.arrival_time == egpu_pkg::VMAX), "unreachable time not saturated")
   `EGPU_ASSERT(a_start_done, clock, reset, (start && $past(!reset, 1)) |-> ##1 vld_ff[0], "accepted transaction lost")

endmodule

[rtl/egpu_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module egpu_div (
   input  logic                        clock,
   input  logic [egpu_pkg::NUM_W-1:0]  dividend,
   input  logic [egpu_pkg::VAL_W-1:0]  divisor,
   output logic [egpu_pkg::NUM_W-1:0]  quotient
);

   logic [egpu_pkg::VAL_W-1:0] rem_ff [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::VAL_W-1:0] rem_in [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::NUM_W-1:0] num_ff [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::NUM_W-1:0] num_in [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::NUM_W-1:0] quo_ff [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::NUM_W-1:0] quo_in [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::VAL_W-1:0] den_ff [egpu_pkg::DIV_STAGES];
   logic [egpu_pkg::VAL_W-1:0] den_in [egpu_pkg::DIV_STAGES];

   // Shift in one dividend bit and try a subtract in each stage
   always_comb begin
      logic [egpu_pkg::VAL_W-1:0] p_rem;
      logic [egpu_pkg::NUM_W-1:0] p_num;
      logic [egpu_pkg::NUM_W-1:0] p_quo;
      logic [egpu_pkg::VAL_W-1:0] p_den;
      logic [egpu_pkg::VAL_W:0]   shifted;
      logic                       ge;
      for (int s = 0; s < egpu_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            p_rem = '0;
            p_num = dividend;
            p_quo = '0;
            p_den = divisor;
         end else begin
            p_rem = rem_ff[s-1];
            p_num = num_ff[s-1];
            p_quo = quo_ff[s-1];
            p_den = den_ff[s-1];
         end
         shifted   = {p_rem, p_num[egpu_pkg::NUM_W-1]};
         ge        = shifted >= {1'b0, p_den};
         rem_in[s] = ge ? egpu_pkg::VAL_W'(shifted - {1'b0, p_den})
                        : egpu_pkg::VAL_W'(shifted);
         num_in[s] = p_num << 1;
         quo_in[s] = {p_quo[egpu_pkg::NUM_W-2:0], ge};
         den_in[s] = p_den;
      end
   end

   // Advance all stages
   always_ff @(posedge clock) begin
      for (int s = 0; s < egpu_pkg::DIV_STAGES; s++) begin
         rem_ff[s] <= rem_in[s];
         num_ff[s] <= num_in[s];
         quo_ff[s] <= quo_in[s];
         den_ff[s] <= den_in[s];
      end
   end

   assign quotient = quo_ff[egpu_pkg::DIV_STAGES-1];

endmodule

[rtl/egpu_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module egpu_sqrt (
   input  logic                        clock,
   input  logic [egpu_pkg::RAD_W-1:0]  radicand,
   output logic [egpu_pkg::ROOT_W-1:0] root
);

   logic [egpu_pkg::REM_W-1:0]  rem_ff  [egpu_pkg::SQRT_STAGES];
   logic [egpu_pkg::REM_W-1:0]  rem_in  [egpu_pkg::SQRT_STAGES];
   logic [egpu_pkg::ROOT_W-1:0] root_ff [egpu_pkg::SQRT_STAGES];
   logic [egpu_pkg::ROOT_W-1:0] root_in [egpu_pkg::SQRT_STAGES];
   logic [egpu_pkg::RAD_W-1:0]  rad_ff  [egpu_pkg::SQRT_STAGES];
   logic [egpu_pkg::RAD_W-1:0]  rad_in  [egpu_pkg::SQRT_STAGES];

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      logic [egpu_pkg::REM_W-1:0]  p_rem;
      logic [egpu_pkg::ROOT_W-1:0] p_root;
      logic [egpu_pkg::RAD_W-1:0]  p_rad;
      logic [egpu_pkg::REM_W-1:0]  cur;
      logic [egpu_pkg::REM_W-1:0]  trial;
      logic                        ge;
      for (int s = 0; s < egpu_pkg::SQRT_STAGES; s++) begin
         if (s == 0) begin
            p_rem  = '0;
            p_root = '0;
            p_rad  = radicand;
         end else begin
            p_rem  = rem_ff[s-1];
            p_root = root_ff[s-1];
            p_rad  = rad_ff[s-1];
         end
         cur        = {p_rem[egpu_pkg::REM_W-3:0],
                       p_rad[egpu_pkg::RAD_W-1:egpu_pkg::RAD_W-2]};
         trial      = egpu_pkg::REM_W'({p_root, 2'b01});
         ge         = cur >= trial;
         rem_in[s]  = ge ? cur - trial : cur;
         root_in[s] = {p_root[egpu_pkg::ROOT_W-2:0], ge};
         rad_in[s]  = p_rad << 2;
      end
   end

   // Advance all stages
   always_ff @(posedge clock) begin
      for (int s = 0; s < egpu_pkg::SQRT_STAGES; s++) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         rad_ff[s]  <= rad_in[s];
      end
   end

   assign root = root_ff[egpu_pkg::SQRT_STAGES-1];

endmodule

[dv/eikonal_grid_point_update_tb.sv]
// Self-checking testbench for the eikonal grid point update pipeline.
`timescale 1ns / 1ps

module eikonal_grid_point_update_tb;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   egpu_pkg::req_type          req_data;
   logic                       rsp_done;
   egpu_pkg::rsp_type          rsp_data;
   logic                       csr_we;
   logic [egpu_pkg::VAL_W-1:0] csr_wdata;

   // Directed row: the point, and an optional hand-written answer
   typedef struct {
      egpu_pkg::req_type r;
      bit                fixed;
      egpu_pkg::rsp_type ans;
   } point_row_type;

   egpu_pkg::rsp_type          arrival_q[$];
   logic [egpu_pkg::VAL_W-1:0] spacing_shadow;
   int unsigned                error_count;
   int unsigned                sent_count;
   int unsigned                checked_count;
   int unsigned                unreach_count;

   // Typed-in answer that travels with the transaction being driven
   bit                         row_fixed;
   egpu_pkg::rsp_type          row_ans;

   eikonal_grid_point_update dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_done  (rsp_done),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Overall time limit
   initial begin
      #4ms;
      $display("eikonal_grid_point_update test failed");
      $finish;
   end

   // floor(sqrt(v)) for v below 2^66
   function automatic logic [33:0] root_floor(logic [65:0] v);
      logic [33:0] lo;
      logic [33:0] hi;
      logic [33:0] mid;
      logic [67:0] sq;
      lo = '0;
      hi = (34'd1 << 33) - 34'd1;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 34'd1) >> 1);
         sq  = mid * mid;
         if (sq <= {2'b00, v}) lo = mid;
         else hi = mid - 34'd1;
      end
      return lo;
   endfunction

   // Expected arrival time of one grid point
   function automatic egpu_pkg::rsp_type arrival_of(egpu_pkg::req_type r,
                                                    logic [egpu_pkg::VAL_W-1:0] gs);
      logic [63:0]       t[4];
      bit                ok[4];
      logic [63:0]       rhs;
      logic [63:0]       best;
      logic [63:0]       cand;
      logic [63:0]       d;
      logic [63:0]       d2;
      logic [64:0]       r2x2;
      logic [65:0]       disc;
      bit                have;
      int                k1;
      egpu_pkg::rsp_type o;
      t[0] = r.north_value;  ok[0] = r.north_valid;
      t[1] = r.east_value;   ok[1] = r.east_valid;
      t[2] = r.south_value;  ok[2] = r.south_valid;
      t[3] = r.west_value;   ok[3] = r.west_valid;
      if (r.speed == '0) rhs = 64'hFFFF_FFFF;
      else begin
         rhs = ({32'b0, gs} << egpu_pkg::FRAC_BITS) / {32'b0, r.speed};
         if (rhs > 64'hFFFF_FFFF) rhs = 64'hFFFF_FFFF;
      end
      have = 0;
      best = '0;
      for (int k = 0; k < 4; k++) begin
         k1 = (k + 1) & 3;
         if (ok[k] && ok[k1]) begin
            d    = (t[k] > t[k1]) ? t[k] - t[k1] : t[k1] - t[k];
            d2   = d * d;
            r2x2 = {rhs * rhs, 1'b0};
            if (r2x2 <= {1'b0, d2}) continue;
            disc = {1'b0, r2x2} - {2'b00, d2};
            cand = (t[k] + t[k1] + {30'b0, root_floor(disc)}) >> 1;
            if (!(cand >= t[k] && cand >= t[k1])) continue;
         end else if (ok[k] || ok[k1]) begin
            cand = (ok[k] ? t[k] : t[k1]) + rhs;
         end else begin
            continue;
         end
         if (!have || cand < best) begin
            best = cand;
            have = 1;
         end
      end
      if (!have) begin
         o.arrival_time = egpu_pkg::VMAX;
         o.unreachable  = 1'b1;
      end else begin
         o.arrival_time = (best > 64'hFFFF_FFFF) ? egpu_pkg::VMAX : best[egpu_pkg::VAL_W-1:0];
         o.unreachable  = 1'b0;
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [egpu_pkg::VAL_W-1:0] got,
                                  logic [egpu_pkg::VAL_W-1:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked_count);
   endtask

   // Predict on every accepted transaction
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         if (row_fixed) arrival_q.push_back(row_ans);
         else arrival_q.push_back(arrival_of(req_data, spacing_shadow));
         sent_count++;
      end
   end

   // Compare every result with the oldest prediction
   always @(posedge clock) begin
      egpu_pkg::rsp_type want;
      if (!reset && rsp_done) begin
         if (arrival_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.arrival_time, '0);
         end else begin
            want = arrival_q.pop_front();
            if (rsp_data.arrival_time !== want.arrival_time)
               report_mismatch("arrival_time", rsp_data.arrival_time, want.arrival_time);
            if (rsp_data.unreachable !== want.unreachable)
               report_mismatch("unreachable", egpu_pkg::VAL_W'(rsp_data.unreachable),
                               egpu_pkg::VAL_W'(want.unreachable));
            if (want.unreachable) unreach_count++;
         end
         checked_count++;
      end
   end

   function automatic egpu_pkg::req_type make_point(logic [31:0] n, logic [31:0] e,
                                                    logic [31:0] s, logic [31:0] w,
                                                    logic [3:0] v, logic [31:0] spd);
      egpu_pkg::req_type r;
      r.north_value = n;  r.east_value = e;  r.south_value = s;  r.west_value = w;
      {r.north_valid, r.east_valid, r.south_valid, r.west_valid} = v;
      r.speed = spd;
      return r;
   endfunction

   // Present one transaction and hold it until taken
   task automatic send_point(egpu_pkg::req_type r, bit fixed, egpu_pkg::rsp_type ans);
      start     <= 1'b1;
      req_data  <= r;
      row_fixed <= fixed;
      row_ans   <= ans;
      forever begin
         @(posedge clock);
         if (start && !busy) break;
      end
   endtask

   // Bursts with random gaps; lower start only when a gap follows
   int unsigned burst_left;
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Drain the pipeline, then write the grid spacing
   task automatic set_spacing(logic [egpu_pkg::VAL_W-1:0] gs);
      int unsigned waited;
      start  <= 1'b0;
      waited = 0;
      while (arrival_q.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (egpu_pkg::LATENCY + 4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= gs;
      @(posedge clock);
      csr_we         <= 1'b0;
      spacing_shadow = gs;
   endtask

   function automatic egpu_pkg::req_type random_point(logic [egpu_pkg::VAL_W-1:0] gs);
      logic [31:0] base;
      logic [31:0] spd;
      logic [31:0] span;
      logic [31:0] v[4];
      int unsigned mode;
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 9))
         0:       spd = $urandom();
         1:       spd = (gs == 0 || $urandom_range(0, 1)) ? 32'd0 : 32'hFFFF_FFFF;
         default: spd = $urandom_range(32'h0000_4000, 32'h0004_0000);
      endcase
      if (mode < 3) begin
         // full-range values
         for (int k = 0; k < 4; k++) v[k] = $urandom();
      end else begin
         // neighbors close together so two-sided updates happen
         span = (spd == 0) ? 32'hFFFF_FFFF : ((gs >> 4) * 32'd3 + 32'd1);
         if (span == 0) span = 32'd1;
         base = (mode == 9) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
         for (int k = 0; k < 4; k++) v[k] = base + ($urandom() % span);
      end
      return make_point(v[0], v[1], v[2], v[3], 4'($urandom()), spd);
   endfunction

   point_row_type     plan[$];
   logic [31:0]       spacing_plan[6];
   egpu_pkg::rsp_type nothing;
   int unsigned       waited;

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      row_fixed      = 1'b0;
      row_ans        = '0;
      spacing_shadow = egpu_pkg::GS_RESET;
      error_count    = 0;
      sent_count     = 0;
      checked_count  = 0;
      unreach_count  = 0;
      burst_left     = 0;
      nothing.arrival_time = egpu_pkg::VMAX;
      nothing.unreachable  = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points at reset spacing
      plan.push_back('{make_point(0, 0, 0, 0, 4'b0000, 32'h0001_0000), 1, nothing});
      plan.push_back('{make_point('1, '1, '1, '1, 4'b0000, '1), 1, nothing});
      plan.push_back('{make_point(0, 0, 0, 0, 4'b1111, 32'h0001_0000), 0, nothing});
      plan.push_back('{make_point('1, '1, '1, '1, 4'b1111, '1), 0, nothing});
      plan.push_back('{make_point('1, 0, 0, 0, 4'b1000, 32'h0001_0000), 0, nothing});
      plan.push_back('{make_point(0, 32'h0002_0000, 0, 0, 4'b0100, 32'h0001_0000), 0, nothing});
      plan.push_back('{make_point(0, 0, 32'h0003_0000, 0, 4'b0010, 32'h0002_0000), 0, nothing});
      plan.push_back('{make_point(0, 0, 0, 32'h0000_8000, 4'b0001, 32'h0000_8000), 0, nothing});
      plan.push_back('{make_point(32'h0001_0000, 32'h0001_0000, 0, 0, 4'b1100, 32'h0001_0000),
                       0, nothing});
      plan.push_back('{make_point(0, 32'h0010_0000, 0, 0, 4'b1100, 32'h0001_0000), 0, nothing});
      plan.push_back('{make_point(0, 32'h0001_6A09, 0, 0, 4'b1100, 32'h0001_0000), 0, nothing});
      plan.push_back('{make_point(0, 32'h0001_6A0A, 0, 0, 4'b1100, 32'h0001_0000), 0, nothing});
      plan.push_back('{make_point(5, 7, 32'h1234_5678, 9, 4'b1111, 0), 0, nothing});
      plan.push_back('{make_point(5, 7, 11, 9, 4'b1111, 1), 0, nothing});
      plan.push_back('{make_point(5, 7, 11, 9, 4'b1111, '1), 0, nothing});
      plan.push_back('{make_point('1, 32'hFFFF_0000, '1, '1, 4'b1100, 32'h0001_0000),
                       0, nothing});
      plan.push_back('{make_point(0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 4'b0011, 32'h0001_0000),
                       0, nothing});
      plan.push_back('{make_point(32'h0100_0000, 0, 32'h0100_8000, 0, 4'b1010, 32'h0001_0000),
                       0, nothing});
      foreach (plan[i]) begin
         send_point(plan[i].r, plan[i].fixed, plan[i].ans);
         pace_sender();
      end

      // Random phases over several grid spacings
      spacing_plan = '{egpu_pkg::GS_RESET, 32'd1, 32'hFFFF_FFFF, 32'd0, $urandom(),
                       32'h0002_8000};
      foreach (spacing_plan[p]) begin
         set_spacing(spacing_plan[p]);
         repeat (330) begin
            send_point(random_point(spacing_shadow), 1'b0, nothing);
            pace_sender();
         end
      end
      start <= 1'b0;

      // Wait for the pipeline to empty
      waited = 0;
      while (arrival_q.size() != 0) begin
         @(posedge clock);
         waited++;
         if (waited > 100000) begin
            $display("eikonal_grid_point_update test failed");
            $finish;
         end
      end
      repeat (egpu_pkg::LATENCY + 10) @(posedge clock);
      if (arrival_q.size() != 0) begin
         error_count++;
         $display("MISMATCH %0d results never arrived", arrival_q.size());
      end

      $display("Covered %0d grid points (%0d unreachable) over %0d spacing settings,",
               sent_count, unreach_count, $size(spacing_plan));
      $display("with bursty input, zero and full-scale speeds, and %0d results checked.",
               checked_count);
      if (error_count == 0) begin
         $display("eikonal_grid_point_update test passed");
      end else begin
         $display("eikonal_grid_point_update test failed");
      end
      $finish;
   end

endmodule
